/* hdl/lcdnw_pkg.sv */
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants of the character display writer
// Request codes, field widths and the byte-pair entry that passes from the
// front end to the back end through the queue.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  localparam int unsigned CountW    = 5;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Request kinds as they arrive on the input tuser.
  localparam logic [1:0] REQ_DATA  = 2'd0;
  localparam logic [1:0] REQ_CMD   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_MOVE  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DDRAM_BASE = 2'd0;
  localparam logic [1:0] CFG_CLEAR_CODE = 2'd1;

  // Display address offsets and cell counts.
  localparam logic [7:0] LINE1_ADDR_OFS = 8'd64;
  localparam logic [5:0] CELLS_LINE     = 6'd16;
  localparam logic [5:0] CELLS_TOTAL    = 6'd32;

  // One queued request: a first byte, optionally followed by a move command.
  typedef struct packed {
    logic       rs;
    logic [7:0] first_byte;
    logic       has_move;
    logic [7:0] move_byte;
  } lcdnw_entry_t;

  // Queue status toward the back end.
  typedef struct packed {
    logic         valid;
    lcdnw_entry_t entry;
  } lcdnw_head_t;

endpackage

/* hdl/lcdnw_front.sv */
// ----------------------------------------------------------------------------
// lcdnw_front: request classifier and cursor tracker
// Holds the configuration registers and the cursor count, and turns each
// accepted request into one queue entry of one or two bytes.
// ----------------------------------------------------------------------------
module lcdnw_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       req_fire,
  input  logic [1:0]                 req_type,
  input  logic [7:0]                 req_value,
  input  logic                       req_line,
  input  logic [3:0]                 req_column,
  output lcdnw_pkg::lcdnw_entry_t    push_entry,
  output logic [lcdnw_pkg::CountW-1:0] cursor_count
);

  logic [7:0]                   ddram_base_r;
  logic [7:0]                   clear_code_r;
  logic [lcdnw_pkg::CountW-1:0] count_r;
  logic [lcdnw_pkg::CountW-1:0] count_nxt;
  logic [5:0]                   next_cells;
  logic                         wrap_line;
  logic                         wrap_home;
  logic [7:0]                   move_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ddram_base_r <= 8'd128;
      clear_code_r <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == lcdnw_pkg::CFG_DDRAM_BASE) begin
        ddram_base_r <= cfg_data;
      end else if (cfg_index == lcdnw_pkg::CFG_CLEAR_CODE) begin
        clear_code_r <= cfg_data;
      end
    end
  end

  always_comb begin
    next_cells = {1'b0, count_r} + 6'd1;
    wrap_line  = (next_cells == lcdnw_pkg::CELLS_LINE);
    wrap_home  = (next_cells == lcdnw_pkg::CELLS_TOTAL);
    move_addr  = ddram_base_r + (req_line ? lcdnw_pkg::LINE1_ADDR_OFS : 8'd0)
                 + {4'd0, req_column};
    push_entry.rs         = 1'b0;
    push_entry.first_byte = req_value;
    push_entry.has_move   = 1'b0;
    push_entry.move_byte  = ddram_base_r + (wrap_line ? lcdnw_pkg::LINE1_ADDR_OFS : 8'd0);
    count_nxt             = count_r;
    case (req_type)
      lcdnw_pkg::REQ_DATA: begin
        push_entry.rs       = 1'b1;
        push_entry.has_move = wrap_line | wrap_home;
        // The line-wrap move lands on cell 16, which equals the incremented count.
        count_nxt           = next_cells[lcdnw_pkg::CountW-1:0];
      end
      lcdnw_pkg::REQ_CMD: begin
        count_nxt = count_r;
      end
      lcdnw_pkg::REQ_CLEAR: begin
        push_entry.first_byte = clear_code_r;
        count_nxt             = '0;
      end
      lcdnw_pkg::REQ_MOVE: begin
        push_entry.first_byte = move_addr;
        count_nxt             = {req_line, req_column};
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (req_fire) begin
      count_r <= count_nxt;
    end
  end

  assign cursor_count = count_r;

endmodule

/* hdl/lcdnw_queue.sv */
// ----------------------------------------------------------------------------
// lcdnw_queue: two-entry queue between front and back end
// A small register queue that lets the request side and the display side
// stall independently.
// ----------------------------------------------------------------------------
module lcdnw_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  input  lcdnw_pkg::lcdnw_entry_t         push_entry,
  input  logic                            pop,
  output lcdnw_pkg::lcdnw_head_t          head,
  output logic                            full,
  output logic [lcdnw_pkg::QueueCntW-1:0] level
);

  lcdnw_pkg::lcdnw_entry_t              mem_r [lcdnw_pkg::QueueDepth];
  logic [lcdnw_pkg::QueuePtrW-1:0]      wr_ptr_r;
  logic [lcdnw_pkg::QueuePtrW-1:0]      rd_ptr_r;
  logic [lcdnw_pkg::QueueCntW-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  assign head.valid = (count_r != '0);
  assign head.entry = mem_r[rd_ptr_r];
  assign full       = (count_r == lcdnw_pkg::QueueCntW'(lcdnw_pkg::QueueDepth));
  assign level      = count_r;

endmodule

/* hdl/lcdnw_back.sv */
// ----------------------------------------------------------------------------
// lcdnw_back: nibble serializer
// Splits the head entry into two or four nibble transfers, high nibble first,
// into an output register that is reloaded in the cycle it is taken.
// ----------------------------------------------------------------------------
module lcdnw_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lcdnw_pkg::lcdnw_head_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_rs,
  output logic [3:0]             out_nibble,
  output logic                   out_last
);

  logic [1:0] step_r;
  logic       valid_r;
  logic       rs_r;
  logic [3:0] nibble_r;
  logic       last_r;
  logic       load;
  logic       final_step;
  logic       rs_sel;
  logic [3:0] nibble_sel;

  assign load       = head.valid && (!valid_r || out_ready);
  assign final_step = (step_r == 2'd3) || ((step_r == 2'd1) && !head.entry.has_move);
  assign pop        = load && final_step;

  always_comb begin
    rs_sel     = 1'b0;
    nibble_sel = head.entry.move_byte[3:0];
    case (step_r)
      2'd0: begin
        rs_sel     = head.entry.rs;
        nibble_sel = head.entry.first_byte[7:4];
      end
      2'd1: begin
        rs_sel     = head.entry.rs;
        nibble_sel = head.entry.first_byte[3:0];
      end
      2'd2: begin
        nibble_sel = head.entry.move_byte[7:4];
      end
      default: begin
        nibble_sel = head.entry.move_byte[3:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      step_r  <= final_step ? 2'd0 : step_r + 2'd1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rs_r     <= rs_sel;
      nibble_r <= nibble_sel;
      last_r   <= final_step;
    end
  end

  assign out_valid  = valid_r;
  assign out_rs     = rs_r;
  assign out_nibble = nibble_r;
  assign out_last   = last_r;

endmodule

/* hdl/char_lcd_nibble_writer.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit bus writer for a 16x2 character display
// Turns data, command, clear and cursor-move requests into nibble transfers
// tagged with register select, and wraps the cursor at the end of each line.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------
//  in_     | input     | in_tvalid/in_tready   | tdata: value, line, column
//          |           |                       | tuser: req_type
//  out_    | output    | out_tvalid/out_tready | tdata: nibble, tuser: reg_sel
//          |           |                       | tlast: final transfer
//  cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// A request becomes two nibble transfers, or four when a data write ends a line
// and a cursor move is appended; the output register sends one nibble per cycle
// unless out_tready stalls it, so the output channel sets the sustained rate. A
// request is accepted in the cycle it arrives as long as the two-entry queue has
// room. The reset is synchronous and active low; it restores the configuration
// defaults, zeroes the cursor count and empties the queue. A stall on the output
// backs up into the queue and then drops in_tready; configuration is always accepted.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] value, [8] line, [12:9] column, [15:13] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // Nibble transfer channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [3:0] nibble, [7:4] zero
  output logic        out_tuser,  // [0] reg_select
  output logic        out_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                                 in_fire;
  logic                                 q_full;
  logic                                 q_pop;
  logic [lcdnw_pkg::QueueCntW-1:0]      q_level;
  lcdnw_pkg::lcdnw_entry_t              push_entry;
  lcdnw_pkg::lcdnw_head_t               q_head;
  logic [lcdnw_pkg::CountW-1:0]         cursor_count;
  logic [3:0]                           out_nibble;

  // Registers can be written at any time; the register file never stalls.
  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Front end: classifies the request and updates the cursor count.
  lcdnw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_fire     (in_fire),
    .req_type     (in_tuser),
    .req_value    (in_tdata[7:0]),
    .req_line     (in_tdata[8]),
    .req_column   (in_tdata[12:9]),
    .push_entry   (push_entry),
    .cursor_count (cursor_count)
  );

  // Queue decouples request acceptance from nibble output.
  lcdnw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .level      (q_level)
  );

  // Back end: serializes each entry into nibble transfers.
  lcdnw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rs     (out_tuser),
    .out_nibble (out_nibble),
    .out_last   (out_tlast)
  );

  assign out_tdata = {4'd0, out_nibble};

  // The queue level never goes past its depth.
  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_level <= lcdnw_pkg::QueueCntW'(lcdnw_pkg::QueueDepth))
    else $error("queue level above depth");

  // A clear request zeroes the cursor count.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == lcdnw_pkg::REQ_CLEAR) |=> (cursor_count == '0))
    else $error("cursor count not cleared");

  // A cursor move sets the count to the target cell.
  a_move_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser == lcdnw_pkg::REQ_MOVE)
      |=> (cursor_count == $past({in_tdata[8], in_tdata[12:9]})))
    else $error("cursor count does not follow move");

  // A queue pop coincides with a loaded final nibble.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_tvalid && out_tlast))
    else $error("queue popped without a final transfer");

endmodule

/* tb/sv/char_lcd_nibble_writer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_tb: self-checking bench for the display nibble writer
// Sends data, command, clear and cursor-move requests, with directed cases
// first and then random traffic over several register settings. The bench
// keeps its own copy of the cursor count and registers, works out the nibble
// transfers each request must produce, and compares every output transfer in
// order. Both channels stall at random, and one long output hold-off fills
// the block's queue.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_tb;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [1:0] CfgSpareLo = 2'd2;
  localparam logic [1:0] CfgSpareHi = 2'd3;

  localparam int NumPhases   = 5;
  localparam int PhaseItems  = 88;
  localparam int HoldCycles  = 80;   // long output hold-off
  localparam int SettleGap   = 4;    // block latency margin after the last transfer
  localparam int IdleLimit   = 1000; // cycles with no transfer anywhere

  // One request as it goes into the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       line;
    logic [3:0] column;
  } lcd_req_t;

  // One nibble transfer as it leaves the block.
  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       last;
  } nibble_xfer_t;

  // A directed row. With n_bytes at zero the predictor supplies the
  // transfers; otherwise the row holds the first byte and, for two bytes,
  // the appended cursor-move command.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       line;
    logic [3:0] column;
    logic [1:0] n_bytes;
    logic       rs1;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  localparam int NumDir = 19;

  // Rows assume the reset settings: move base 0x80, clear code 0x01.
  dir_row_t dir_rows [NumDir] = '{
    {lcdnw_pkg::REQ_DATA,  8'h00, 1'b0, 4'h0, 2'd1, 1'b1, 8'h00, 8'h00}, // count 1
    {lcdnw_pkg::REQ_DATA,  8'hFF, 1'b1, 4'hF, 2'd1, 1'b1, 8'hFF, 8'h00}, // line/column ignored
    {lcdnw_pkg::REQ_CMD,   8'h00, 1'b0, 4'h0, 2'd1, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_CMD,   8'hFF, 1'b1, 4'hF, 2'd1, 1'b0, 8'hFF, 8'h00},
    {lcdnw_pkg::REQ_DATA,  8'h5A, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00}, // count 3
    {lcdnw_pkg::REQ_CLEAR, 8'hA5, 1'b1, 4'h7, 2'd1, 1'b0, 8'h01, 8'h00}, // value ignored
    {lcdnw_pkg::REQ_MOVE,  8'hFF, 1'b0, 4'h0, 2'd1, 1'b0, 8'h80, 8'h00}, // home
    {lcdnw_pkg::REQ_MOVE,  8'h00, 1'b1, 4'hF, 2'd1, 1'b0, 8'hCF, 8'h00}, // count 31
    {lcdnw_pkg::REQ_DATA,  8'h41, 1'b0, 4'h0, 2'd2, 1'b1, 8'h41, 8'h80}, // wraps to home
    {lcdnw_pkg::REQ_MOVE,  8'h00, 1'b0, 4'hF, 2'd1, 1'b0, 8'h8F, 8'h00}, // count 15
    {lcdnw_pkg::REQ_DATA,  8'h5A, 1'b1, 4'h3, 2'd2, 1'b1, 8'h5A, 8'hC0}, // wraps to line 1
    {lcdnw_pkg::REQ_DATA,  8'h33, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_CMD,   8'h01, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00}, // count unchanged
    {lcdnw_pkg::REQ_MOVE,  8'h77, 1'b1, 4'hE, 2'd0, 1'b0, 8'h00, 8'h00}, // count 30
    {lcdnw_pkg::REQ_DATA,  8'h96, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_DATA,  8'h69, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_CLEAR, 8'h00, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_MOVE,  8'h00, 1'b0, 4'h1, 2'd0, 1'b0, 8'h00, 8'h00},
    {lcdnw_pkg::REQ_DATA,  8'hC3, 1'b0, 4'h0, 2'd0, 1'b0, 8'h00, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [15:0] in_tdata;   // [7:0] value, [8] line, [12:9] column, [15:13] zero
  logic [1:0] in_tuser;    // [1:0] req_type
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [3:0] nibble, [7:4] zero
  logic       out_tuser;   // [0] reg_select
  logic       out_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // Predictor state: mirrors the block's registers and cursor count.
  logic [7:0] model_base;
  logic [7:0] model_clear;
  logic [4:0] model_cursor;

  nibble_xfer_t pending_nibbles [$];
  int           err_cnt = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           hold_req = 1'b0;
  int           quiet_cycles = 0;

  char_lcd_nibble_writer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A byte always leaves as two transfers, high nibble first; only the low
  // nibble can carry the end-of-request flag.
  task automatic push_byte(input logic rs, input logic [7:0] bval, input logic final_xfer);
    pending_nibbles.push_back('{rs, bval[7:4], 1'b0});
    pending_nibbles.push_back('{rs, bval[3:0], final_xfer});
  endtask

  // A cursor move sends base + line*64 + column (wrapping at 256) as a
  // command and sets the count to the cell index of the new position.
  task automatic model_move(input logic ln, input logic [3:0] col, input bit emit);
    logic [7:0] addr;
    addr = model_base + (ln ? lcdnw_pkg::LINE1_ADDR_OFS : 8'd0) + {4'd0, col};
    model_cursor = {ln, col};
    if (emit) push_byte(1'b0, addr, 1'b1);
  endtask

  // Updates the predicted state for one accepted request and, if emit is
  // set, queues the transfers the block must send for it.
  task automatic predict_nibbles(input lcd_req_t r, input bit emit);
    logic [5:0] next_cnt;
    logic       adds_move;
    next_cnt  = '0;
    adds_move = 1'b0;
    case (r.kind)
      lcdnw_pkg::REQ_DATA: begin
        // Reaching 16 adds a move to line 1, reaching 32 a move to home.
        next_cnt  = {1'b0, model_cursor} + 6'd1;
        adds_move = (next_cnt == lcdnw_pkg::CELLS_LINE) ||
                    (next_cnt == lcdnw_pkg::CELLS_TOTAL);
        if (emit) push_byte(1'b1, r.value, !adds_move);
        model_cursor = next_cnt[4:0];
        if (next_cnt == lcdnw_pkg::CELLS_LINE)
          model_move(1'b1, 4'd0, emit);
        else if (next_cnt == lcdnw_pkg::CELLS_TOTAL)
          model_move(1'b0, 4'd0, emit);
      end
      lcdnw_pkg::REQ_CMD: begin
        // A raw command leaves the count alone, whatever it does on the glass.
        if (emit) push_byte(1'b0, r.value, 1'b1);
      end
      lcdnw_pkg::REQ_CLEAR: begin
        if (emit) push_byte(1'b0, model_clear, 1'b1);
        model_cursor = '0;
      end
      lcdnw_pkg::REQ_MOVE: begin
        model_move(r.line, r.column, emit);
      end
      default: begin
        model_move(r.line, r.column, emit);
      end
    endcase
  endtask

  // Offers one request, after an optional random gap, and returns at the
  // edge where it is taken. in_tvalid stays high: the caller either offers
  // the next request in the same step or lowers it through drain_results.
  task automatic send_req(input lcd_req_t r);
    if (tx_idle_on && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, r.column, r.line, r.value};
    in_tuser  <= r.kind;
    do @(posedge clk); while (!in_tready);
  endtask

  // Stops offering requests and waits until every predicted transfer has
  // been seen, then gives the block time to settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_nibbles.size() != 0) @(posedge clk);
    repeat (SettleGap) @(posedge clk);
  endtask

  // Writes both registers and then one of the unused indexes, keeping
  // cfg_valid high across the three transfers.
  task automatic write_settings(input logic [7:0] base_v, input logic [7:0] clear_v,
                                input logic [1:0] spare_idx, input logic [7:0] spare_v);
    logic [1:0] idx [3];
    logic [7:0] dat [3];
    idx = '{lcdnw_pkg::CFG_DDRAM_BASE, lcdnw_pkg::CFG_CLEAR_CODE, spare_idx};
    dat = '{base_v, clear_v, spare_v};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      do @(posedge clk); while (!cfg_ready);
      if (idx[i] == lcdnw_pkg::CFG_DDRAM_BASE)
        model_base = dat[i];
      else if (idx[i] == lcdnw_pkg::CFG_CLEAR_CODE)
        model_clear = dat[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Random request. Data writes dominate so the cursor keeps crossing line
  // and home boundaries; moves favor the last columns so wraps come soon.
  // Unused fields always carry random bits.
  function automatic lcd_req_t random_req();
    lcd_req_t r;
    int       pick;
    pick     = $urandom_range(99);
    r.value  = 8'($urandom_range(0, 255));
    r.line   = 1'($urandom_range(0, 1));
    r.column = 4'($urandom_range(0, 15));
    if (pick < 55)
      r.kind = lcdnw_pkg::REQ_DATA;
    else if (pick < 68)
      r.kind = lcdnw_pkg::REQ_CMD;
    else if (pick < 76)
      r.kind = lcdnw_pkg::REQ_CLEAR;
    else begin
      r.kind = lcdnw_pkg::REQ_MOVE;
      if ($urandom_range(1) == 1) r.column = 4'($urandom_range(12, 15));
    end
    return r;
  endfunction

  // Output side: random stalls, a stretch with none, and on request one
  // long hold-off counted here so the queue fills and in_tready drops.
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !rx_idle_on || ($urandom_range(99) >= 15);
      end
    end
  end

  // Every accepted transfer is matched against the oldest prediction.
  always @(posedge clk) begin : check_nibbles
    nibble_xfer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_nibbles.size() == 0) begin
        $display("%0t: transfer with nothing predicted: rs=%0b nibble=%h last=%0b",
                 $time, out_tuser, out_tdata[3:0], out_tlast);
        err_cnt++;
      end else begin
        want = pending_nibbles.pop_front();
        if (out_tuser !== want.rs) begin
          $display("%0t: reg_select expected %0b actual %0b", $time, want.rs, out_tuser);
          err_cnt++;
        end
        if (out_tdata[3:0] !== want.nib) begin
          $display("%0t: nibble expected %h actual %h", $time, want.nib, out_tdata[3:0]);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %0b actual %0b", $time, want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    lcd_req_t   req;
    logic [7:0] base_v;
    logic [7:0] clear_v;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    model_base   = 8'd128;
    model_clear  = 8'd1;
    model_cursor = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings.
    foreach (dir_rows[i]) begin
      req = '{dir_rows[i].kind, dir_rows[i].value, dir_rows[i].line, dir_rows[i].column};
      send_req(req);
      if (dir_rows[i].n_bytes == 2'd0) begin
        predict_nibbles(req, 1'b1);
      end else begin
        predict_nibbles(req, 1'b0);
        push_byte(dir_rows[i].rs1, dir_rows[i].b1, dir_rows[i].n_bytes == 2'd1);
        if (dir_rows[i].n_bytes == 2'd2) push_byte(1'b0, dir_rows[i].b2, 1'b1);
      end
    end

    // Random part: each phase runs under its own register settings, with
    // the extremes first and the reset values last.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_results();
      case (ph)
        0:       begin base_v = 8'h00; clear_v = 8'h00; end
        1:       begin base_v = 8'hFF; clear_v = 8'hFF; end
        4:       begin base_v = 8'h80; clear_v = 8'h01; end
        default: begin
          base_v  = 8'($urandom_range(0, 255));
          clear_v = 8'($urandom_range(0, 255));
        end
      endcase
      write_settings(base_v, clear_v, (ph % 2 == 1) ? CfgSpareHi : CfgSpareLo,
                     8'($urandom_range(0, 255)));
      // Phase 1 runs flat out on both sides.
      tx_idle_on = (ph != 1);
      rx_idle_on = (ph != 1);
      for (int k = 0; k < PhaseItems; k++) begin
        if (ph == 2 && k == 30) hold_req = 1'b1;
        if (ph == 3 && k == 46) drain_results();
        req = random_req();
        send_req(req);
        predict_nibbles(req, 1'b1);
      end
    end

    drain_results();
    repeat (2 * SettleGap) @(posedge clk);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
